// File: sv/sbhe_pkg.sv
// Shared types, constants and hash helper functions for the selectable byte hash engine.
// Depends on nothing; used by sbhe_fold, selectable_byte_hash_engine and the testbench files.

package sbhe_pkg;

    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [63:0] DJB_INIT  = 64'd5381;
    localparam logic [63:0] FNV_INIT  = 64'hCBF2_9CE4_8422_2325;
    localparam int          CRC_STEPS = 8;

    typedef enum logic [1:0] {
        ALG_CRC32 = 2'd0,
        ALG_DJB2  = 2'd1,
        ALG_FNV1A = 2'd2
    } alg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [63:0] hash;
        logic [63:0] digest;
    } fold_t;

    function automatic logic [63:0] init_value(input alg_t alg);
        logic [63:0] v;
        case (alg)
            ALG_CRC32: v = {32'd0, CRC_INIT};
            ALG_DJB2:  v = DJB_INIT;
            ALG_FNV1A: v = FNV_INIT;
            default:   v = 64'd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < CRC_STEPS; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // Multiply by the FNV prime 2^40 + 0x1b3, modulo 2^64.
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// File: sv/sbhe_fold.sv
// Combinational fold of one item into the running hash, with digest and reload.
// Depends on sbhe_pkg.

module sbhe_fold
(
    input  logic [63:0]         hash,
    input  sbhe_pkg::alg_t      alg,
    input  sbhe_pkg::item_t     item,
    output sbhe_pkg::fold_t     result
);

    logic [63:0] folded;
    logic [63:0] updated;
    logic [63:0] digest;

    always_comb
    begin
        case (alg)
            sbhe_pkg::ALG_CRC32:
                folded = {32'd0, sbhe_pkg::crc_byte(hash[31:0], item.data_byte)};
            sbhe_pkg::ALG_DJB2:
                folded = (hash << 5) + hash + {56'd0, item.data_byte};
            sbhe_pkg::ALG_FNV1A:
                folded = sbhe_pkg::fnv_mul(hash ^ {56'd0, item.data_byte});
            default:
                folded = 64'd0;
        endcase
    end

    assign updated = item.byte_present ? folded : hash;

    always_comb
    begin
        case (alg)
            sbhe_pkg::ALG_CRC32: digest = {32'd0, ~updated[31:0]};
            sbhe_pkg::ALG_DJB2:  digest = updated;
            sbhe_pkg::ALG_FNV1A: digest = updated;
            default:             digest = 64'd0;
        endcase
    end

    assign result.digest = digest;
    assign result.hash   = item.last_byte ? sbhe_pkg::init_value(alg) : updated;

endmodule

// File: sv/selectable_byte_hash_engine.sv
// Top level of the selectable byte hash engine: input register, running hash, result register.
// Depends on sbhe_pkg and sbhe_fold.
//
// Usage:
//   The input channel (in_valid, in_stall) carries one message byte per item with
//   byte_present and last_byte flags. An item with last_byte set ends the message and
//   produces one digest on the output channel (out_valid, out_stall); other items
//   produce nothing.
//   The configuration channel (cfg_valid, cfg_ready) writes the algorithm register:
//   0 CRC-32, 1 DJB2, 2 FNV-1a 64-bit. Each write reloads the running hash with the
//   initial value of the new algorithm. cfg_ready is always high; write only when idle.
//   Throughput: one item per cycle while in_stall is low, set by the combinational fold
//   between the input register and the running hash register.
//   Digest path: the last item's digest is computed from the input register and captured
//   in the result register, which drives the output.
//   Reset: the algorithm returns to CRC-32, the running hash to 0xFFFFFFFF, and both
//   channels empty.
//   Stall: a pending digest holds while out_stall is high; non-last items keep
//   flowing, and a last item waits in the input register, raising in_stall.

module selectable_byte_hash_engine
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  algorithm,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest
);

    sbhe_pkg::alg_t  alg_reg;
    logic [63:0]     hash_reg;
    logic            s1_valid_reg;
    sbhe_pkg::item_t s1_item_reg;
    logic            out_valid_reg;
    logic [63:0]     digest_reg;

    sbhe_pkg::item_t in_item;
    sbhe_pkg::fold_t fold;
    logic            cfg_write;
    logic            in_accept;
    logic            s1_advance;
    logic            out_load;

    assign in_item.data_byte    = data_byte;
    assign in_item.byte_present = byte_present;
    assign in_item.last_byte    = last_byte;

    sbhe_fold u_fold
    (
        .hash   (hash_reg),
        .alg    (alg_reg),
        .item   (s1_item_reg),
        .result (fold)
    );

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign s1_advance = s1_valid_reg
                        && !(s1_item_reg.last_byte && out_valid_reg && out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;
    assign out_load   = s1_advance && s1_item_reg.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alg_reg       <= sbhe_pkg::ALG_CRC32;
            hash_reg      <= sbhe_pkg::init_value(sbhe_pkg::ALG_CRC32);
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                alg_reg  <= sbhe_pkg::alg_t'(algorithm);
                hash_reg <= sbhe_pkg::init_value(sbhe_pkg::alg_t'(algorithm));
            end
            else if (s1_advance)
            begin
                hash_reg <= fold.hash;
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_item;
        end
        if (out_load)
        begin
            digest_reg <= fold.digest;
        end
    end

    assign out_valid = out_valid_reg;
    assign digest    = digest_reg;

    a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> hash_reg == sbhe_pkg::init_value(alg_reg))
        else $error("running hash not reloaded after algorithm write");

    a_digest_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_item_reg.last_byte))
        else $error("digest produced without a last item");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s1_item_reg.last_byte && out_valid_reg)
        else $error("input stalled without a blocked last item");

endmodule

// File: tb/sbhe_digest_checker.sv
// Digest checker for the selectable byte hash engine: watches the config, input and output
// channels, keeps its own running hash for the active algorithm, and compares each digest in order.
// Depends on sbhe_pkg for the algorithm encoding.

module sbhe_digest_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  algorithm,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] digest,
    output int          mismatch_count,
    output int          digests_pending,
    output int          digests_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] CRC_SEED  = 64'h0000_0000_FFFF_FFFF;
    localparam logic [31:0] CRC_REFL  = 32'hEDB8_8320;
    localparam logic [63:0] DJB_SEED  = 64'd5381;
    localparam logic [63:0] FNV_SEED  = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

    sbhe_pkg::alg_t active_alg = sbhe_pkg::ALG_CRC32;
    logic [63:0]    running_value = CRC_SEED;
    logic [63:0]    expected_digests[$];
    logic [63:0]    want;
    int             errors = 0;
    int             checked = 0;

    function automatic logic [63:0] seed_for(input sbhe_pkg::alg_t a);
        case (a)
            sbhe_pkg::ALG_CRC32: return CRC_SEED;
            sbhe_pkg::ALG_DJB2:  return DJB_SEED;
            sbhe_pkg::ALG_FNV1A: return FNV_SEED;
            default:             return 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] absorb_byte(input logic [63:0] h, input sbhe_pkg::alg_t a,
                                                input logic [7:0] b);
        logic [31:0] c;
        int          k;
        case (a)
            sbhe_pkg::ALG_CRC32:
            begin
                c = h[31:0] ^ {24'd0, b};
                for (k = 0; k < 8; k++)
                begin
                    c = c[0] ? ((c >> 1) ^ CRC_REFL) : (c >> 1);
                end
                return {32'd0, c};
            end
            sbhe_pkg::ALG_DJB2:  return h * 64'd33 + {56'd0, b};
            sbhe_pkg::ALG_FNV1A: return (h ^ {56'd0, b}) * FNV_PRIME;
            default:             return 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] close_digest(input logic [63:0] h, input sbhe_pkg::alg_t a);
        case (a)
            sbhe_pkg::ALG_CRC32: return {32'd0, ~h[31:0]};
            sbhe_pkg::ALG_DJB2,
            sbhe_pkg::ALG_FNV1A: return h;
            default:             return 64'd0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_alg    = sbhe_pkg::ALG_CRC32;
            running_value = seed_for(sbhe_pkg::ALG_CRC32);
            expected_digests.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_digests.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected digest, expected none, got %h", $time, digest);
                end
                else
                begin
                    want = expected_digests.pop_front();
                    checked++;
                    if (digest !== want)
                    begin
                        errors++;
                        $display("%0t: digest mismatch, expected %h, got %h",
                                 $time, want, digest);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                active_alg    = sbhe_pkg::alg_t'(algorithm);
                running_value = seed_for(active_alg);
            end
            if (in_valid && !in_stall)
            begin
                if (byte_present)
                    running_value = absorb_byte(running_value, active_alg, data_byte);
                if (last_byte)
                begin
                    expected_digests.push_back(close_digest(running_value, active_alg));
                    running_value = seed_for(active_alg);
                end
            end
        end
        mismatch_count  <= errors;
        digests_pending <= expected_digests.size();
        digests_checked <= checked;
    end

endmodule

// File: tb/tb_selectable_byte_hash_engine.sv
// Top-level bench for the selectable byte hash engine: clock, reset, directed and random
// byte streams under several flow-control mixes, and the final verdict.
// Depends on sbhe_pkg, selectable_byte_hash_engine and sbhe_digest_checker.

module tb_selectable_byte_hash_engine;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS = 85;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  algorithm = 2'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        byte_present = 1'b0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] digest;

    int mismatch_count;
    int digests_pending;
    int digests_checked;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;

    selectable_byte_hash_engine uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .algorithm    (algorithm),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest       (digest)
    );

    sbhe_digest_checker checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .algorithm       (algorithm),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .byte_present    (byte_present),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .digest          (digest),
        .mismatch_count  (mismatch_count),
        .digests_pending (digests_pending),
        .digests_checked (digests_checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task send_item(input logic [7:0] b, input logic present, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        byte_present <= present;
        last_byte    <= last;
        do
            @(posedge clk);
        while (in_stall);
        if (present || last)
            items_sent++;
    endtask

    task drain_digests();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (digests_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_algorithm(input sbhe_pkg::alg_t a);
        drain_digests();
        cfg_valid <= 1'b1;
        algorithm <= a;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task send_random_messages(input int count);
        int start;
        int len;
        int i;
        start = items_sent;
        while (items_sent - start < count)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(0, 8);
            for (i = 0; i < len; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_item(8'($urandom_range(255)), 1'b0, 1'b0);
                send_item(8'($urandom_range(255)), 1'b1, 1'b0);
            end
            send_item(8'($urandom_range(255)), ($urandom_range(4) != 0), 1'b1);
            if ($urandom_range(19) == 0)
                drain_digests();
        end
        if ($urandom_range(1) == 1)
        begin
            repeat ($urandom_range(1, 5)) send_item(8'($urandom_range(255)), 1'b1, 1'b0);
        end
    endtask

    initial
    begin
        sbhe_pkg::alg_t order[3];
        int             ph;
        int             j;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state is CRC-32
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h31, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h32, 1'b1, 1'b0);
        send_item(8'h33, 1'b1, 1'b1);
        send_item(8'hA5, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hAA, 1'b1, 1'b0);
        write_algorithm(sbhe_pkg::ALG_DJB2);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'h7F, 1'b1, 1'b0);
        write_algorithm(sbhe_pkg::ALG_FNV1A);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hFE, 1'b1, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        write_algorithm(sbhe_pkg::ALG_FNV1A);
        send_item(8'h55, 1'b1, 1'b1);
        write_algorithm(sbhe_pkg::ALG_CRC32);
        send_item(8'h00, 1'b0, 1'b1);

        order[0] = sbhe_pkg::ALG_CRC32;
        order[1] = sbhe_pkg::ALG_DJB2;
        order[2] = sbhe_pkg::ALG_FNV1A;
        for (ph = 0; ph < 4; ph++)
        begin
            drain_digests();
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            for (j = 0; j < 3; j++)
            begin
                write_algorithm(order[(ph % 2 == 0) ? j : 2 - j]);
                send_random_messages(RANDOM_ITEMS);
            end
        end

        drain_digests();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (10) @(posedge clk);

        $display("Sent %0d items and checked %0d digests across CRC-32, DJB2 and FNV-1a,",
                 items_sent, digests_checked);
        $display("with no gaps, sparse input, heavy output stall and mixed gaps and stalls.");
        if (mismatch_count == 0 && digests_pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            if (digests_pending != 0)
                $display("%0t: %0d digests never arrived", $time, digests_pending);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
